### design/tpsd_pkg.sv
// ----------------------------------------------------------------------------
// Targa pixel stream decoder package
// Shared types, constants and the pixel and colormap word decoder.
// ----------------------------------------------------------------------------
package tpsd_pkg;

    localparam int MAX_DIM     = 4096;
    localparam int DIM_W       = $clog2(MAX_DIM + 1);
    localparam int MAP_ENTRIES = 256;
    localparam int MAP_AW      = $clog2(MAP_ENTRIES);
    localparam int MAP_PW      = $clog2(MAP_ENTRIES + 1);

    localparam logic [2:0] FMT_8  = 3'd0;
    localparam logic [2:0] FMT_15 = 3'd1;
    localparam logic [2:0] FMT_16 = 3'd2;
    localparam logic [2:0] FMT_24 = 3'd3;
    localparam logic [2:0] FMT_32 = 3'd4;

    localparam logic [1:0] ILV_TWO  = 2'd1;
    localparam logic [1:0] ILV_FOUR = 2'd2;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_MAP   = 2'd1,
        KIND_BODY  = 2'd2,
        KIND_PULL  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        REG_PIXEL_FORMAT = 3'd0,
        REG_MAP_FORMAT   = 3'd1,
        REG_USE_PALETTE  = 3'd2,
        REG_RLE_ENABLE   = 3'd3,
        REG_IMAGE_WIDTH  = 3'd4,
        REG_IMAGE_HEIGHT = 3'd5,
        REG_TOP_ORIGIN   = 3'd6,
        REG_INTERLEAVE   = 3'd7
    } t_reg_index;

    typedef struct packed {
        logic [2:0]       pixel_format;
        logic [2:0]       map_format;
        logic             use_palette;
        logic             rle_enable;
        logic [DIM_W-1:0] image_width;
        logic [DIM_W-1:0] image_height;
        logic             top_origin;
        logic [1:0]       interleave_mode;
    } t_cfg;

    typedef struct packed {
        logic [31:0] color;
        logic [15:0] idx;
    } t_decoded;

    typedef struct packed {
        logic              en;
        logic [MAP_AW-1:0] addr;
        logic [31:0]       data;
    } t_pal_wr;

    typedef struct packed {
        logic [31:0] color;
        logic [15:0] idx;
        logic        use_pal;
        logic [11:0] column;
        logic [11:0] row;
        logic [6:0]  repeats;
        logic        last;
    } t_result;

    function automatic logic [2:0] norm_fmt(logic [2:0] fmt);
        return (fmt > FMT_32) ? FMT_24 : fmt;
    endfunction

    function automatic logic [2:0] fmt_bytes(logic [2:0] fmt);
        logic [2:0] f;
        f = norm_fmt(fmt);
        case (f)
            FMT_8:           return 3'd1;
            FMT_15, FMT_16:  return 3'd2;
            FMT_32:          return 3'd4;
            default:         return 3'd3;
        endcase
    endfunction

    // Color is packed as red, green, blue, alpha from the top byte down.
    function automatic t_decoded decode_word(logic [2:0] fmt, logic [31:0] word);
        logic [2:0] f;
        logic [7:0] j;
        logic [7:0] k;
        logic [7:0] a;
        t_decoded   d;
        f = norm_fmt(fmt);
        j = word[7:0];
        k = word[15:8];
        case (f)
            FMT_8: begin
                d.idx   = {8'd0, j};
                d.color = {j, j, j, 8'hFF};
            end
            FMT_15, FMT_16: begin
                a       = (f == FMT_15 || k[7]) ? 8'hFF : 8'h00;
                d.idx   = {k, j};
                d.color = {k[6:2], 3'b000, k[1:0], j[7:5], 3'b000, j[4:0], 3'b000, a};
            end
            FMT_32: begin
                d.idx   = 16'd0;
                d.color = {word[23:16], k, j, word[31:24]};
            end
            default: begin
                d.idx   = 16'd0;
                d.color = {word[23:16], k, j, 8'hFF};
            end
        endcase
        return d;
    endfunction

endpackage

### design/tpsd_parser.sv
// ----------------------------------------------------------------------------
// Targa pixel stream parser
// Byte assembly, run-length packets, palette loading and pixel placement.
// ----------------------------------------------------------------------------
module tpsd_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  tpsd_pkg::t_kind      i_kind,
    input  logic [7:0]           i_byte,
    input  tpsd_pkg::t_cfg       i_cfg,
    output tpsd_pkg::t_pal_wr    o_pal_wr,
    output logic                 o_res_valid,
    output tpsd_pkg::t_result    o_res
);

    localparam int DW = tpsd_pkg::DIM_W;
    localparam int PW = tpsd_pkg::MAP_PW;

    logic [PW-1:0]  r_pal_ptr,    n_pal_ptr;
    logic [1:0]     r_pal_phase,  n_pal_phase;
    logic [23:0]    r_map_held,   n_map_held;
    logic [1:0]     r_pix_phase,  n_pix_phase;
    logic [23:0]    r_held,       n_held;
    logic [31:0]    r_last_color, n_last_color;
    logic [15:0]    r_last_index, n_last_index;
    logic [7:0]     r_run_count,  n_run_count;
    logic           r_run_rep,    n_run_rep;
    logic           r_rep_ready,  n_rep_ready;
    logic [11:0]    r_column,     n_column;
    logic [DW-1:0]  r_true_row,   n_true_row;
    logic [DW-1:0]  r_base_row,   n_base_row;
    logic [DW-1:0]  r_rows_done,  n_rows_done;

    logic [DW-1:0]  w_dim;
    logic [DW-1:0]  h_dim;
    logic [31:0]    map_word;
    logic [31:0]    pix_word;
    logic [2:0]     map_n;
    logic [2:0]     pix_n;
    tpsd_pkg::t_decoded map_dec;
    tpsd_pkg::t_decoded pix_dec;
    logic [7:0]     run_dec;
    logic [DW-1:0]  col_next;
    logic           col_wrap;
    logic [2:0]     row_step;
    logic [DW:0]    row_sum;
    logic           row_over;
    logic [DW-1:0]  base_inc;
    logic [DW-1:0]  rows_after;
    logic           finished;
    logic           done;
    logic [DW-1:0]  dest;
    logic           do_emit;
    logic [31:0]    e_color;
    logic [15:0]    e_idx;
    logic [7:0]     e_rep;

    assign w_dim = (i_cfg.image_width == '0) ? DW'(1) :
                   (i_cfg.image_width > DW'(tpsd_pkg::MAX_DIM)) ? DW'(tpsd_pkg::MAX_DIM) :
                   i_cfg.image_width;
    assign h_dim = (i_cfg.image_height == '0) ? DW'(1) :
                   (i_cfg.image_height > DW'(tpsd_pkg::MAX_DIM)) ? DW'(tpsd_pkg::MAX_DIM) :
                   i_cfg.image_height;

    assign map_word = {8'd0, r_map_held} | ({24'd0, i_byte} << {r_pal_phase, 3'b000});
    assign pix_word = {8'd0, r_held} | ({24'd0, i_byte} << {r_pix_phase, 3'b000});
    assign map_n    = tpsd_pkg::fmt_bytes(i_cfg.map_format);
    assign pix_n    = tpsd_pkg::fmt_bytes(i_cfg.pixel_format);
    assign map_dec  = tpsd_pkg::decode_word(i_cfg.map_format, map_word);
    assign pix_dec  = tpsd_pkg::decode_word(i_cfg.pixel_format, pix_word);
    assign run_dec  = r_run_count - 8'd1;

    assign col_next   = {1'b0, r_column} + DW'(1);
    assign col_wrap   = (col_next >= w_dim);
    assign row_step   = (i_cfg.interleave_mode == tpsd_pkg::ILV_FOUR) ? 3'd4 :
                        (i_cfg.interleave_mode == tpsd_pkg::ILV_TWO)  ? 3'd2 : 3'd1;
    assign row_sum    = {1'b0, r_true_row} + (DW+1)'(row_step);
    assign row_over   = (row_sum >= {1'b0, h_dim});
    assign base_inc   = r_base_row + DW'(1);
    assign rows_after = col_wrap ? (r_rows_done + DW'(1)) : r_rows_done;
    assign finished   = (rows_after >= h_dim);
    assign done       = (r_rows_done >= h_dim);
    assign dest       = i_cfg.top_origin ? r_true_row : (h_dim - DW'(1) - r_true_row);

    always_comb begin
        n_pal_ptr    = r_pal_ptr;
        n_pal_phase  = r_pal_phase;
        n_map_held   = r_map_held;
        n_pix_phase  = r_pix_phase;
        n_held       = r_held;
        n_last_color = r_last_color;
        n_last_index = r_last_index;
        n_run_count  = r_run_count;
        n_run_rep    = r_run_rep;
        n_rep_ready  = r_rep_ready;
        n_column     = r_column;
        n_true_row   = r_true_row;
        n_base_row   = r_base_row;
        n_rows_done  = r_rows_done;
        o_pal_wr     = '0;
        do_emit      = 1'b0;
        e_color      = r_last_color;
        e_idx        = r_last_index;
        e_rep        = 8'd0;

        if (i_step) begin
            case (i_kind)
                tpsd_pkg::KIND_START: begin
                    n_pal_ptr    = '0;
                    n_pal_phase  = '0;
                    n_map_held   = '0;
                    n_pix_phase  = '0;
                    n_held       = '0;
                    n_last_color = '0;
                    n_last_index = '0;
                    n_run_count  = '0;
                    n_run_rep    = 1'b0;
                    n_rep_ready  = 1'b0;
                    n_column     = '0;
                    n_true_row   = '0;
                    n_base_row   = '0;
                    n_rows_done  = '0;
                end
                tpsd_pkg::KIND_MAP: begin
                    if (({1'b0, r_pal_phase} + 3'd1) < map_n) begin
                        n_map_held  = map_word[23:0];
                        n_pal_phase = r_pal_phase + 2'd1;
                    end else begin
                        if (r_pal_ptr < PW'(tpsd_pkg::MAP_ENTRIES)) begin
                            o_pal_wr.en   = 1'b1;
                            o_pal_wr.addr = r_pal_ptr[tpsd_pkg::MAP_AW-1:0];
                            o_pal_wr.data = map_dec.color;
                            n_pal_ptr     = r_pal_ptr + PW'(1);
                        end
                        n_map_held  = '0;
                        n_pal_phase = '0;
                    end
                end
                tpsd_pkg::KIND_PULL: begin
                    if (!done) begin
                        if (!r_rep_ready || r_run_count == 8'd0) begin
                            n_rep_ready = 1'b0;
                        end else begin
                            n_run_count = run_dec;
                            if (run_dec == 8'd0) begin
                                n_rep_ready = 1'b0;
                            end
                            do_emit = 1'b1;
                            e_rep   = run_dec;
                        end
                    end
                end
                tpsd_pkg::KIND_BODY: begin
                    if (!done && !(i_cfg.rle_enable && r_rep_ready)) begin
                        if (i_cfg.rle_enable && r_run_count == 8'd0) begin
                            n_run_rep   = i_byte[7];
                            n_run_count = {1'b0, i_byte[6:0]} + 8'd1;
                            n_pix_phase = '0;
                            n_held      = '0;
                        end else if (({1'b0, r_pix_phase} + 3'd1) < pix_n) begin
                            n_held      = pix_word[23:0];
                            n_pix_phase = r_pix_phase + 2'd1;
                        end else begin
                            n_held       = '0;
                            n_pix_phase  = '0;
                            n_last_color = pix_dec.color;
                            n_last_index = pix_dec.idx;
                            do_emit      = 1'b1;
                            e_color      = pix_dec.color;
                            e_idx        = pix_dec.idx;
                            if (i_cfg.rle_enable) begin
                                n_run_count = run_dec;
                                if (r_run_rep && run_dec != 8'd0) begin
                                    n_rep_ready = 1'b1;
                                    e_rep       = run_dec;
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase

            if (do_emit) begin
                if (col_wrap) begin
                    n_column    = '0;
                    n_rows_done = rows_after;
                    if (row_over) begin
                        n_base_row = base_inc;
                        n_true_row = base_inc;
                    end else begin
                        n_true_row = row_sum[DW-1:0];
                    end
                end else begin
                    n_column = col_next[11:0];
                end
                if (finished) begin
                    n_run_count = '0;
                    n_run_rep   = 1'b0;
                    n_rep_ready = 1'b0;
                    n_pix_phase = '0;
                    n_held      = '0;
                end
            end
        end
    end

    always_comb begin
        o_res_valid   = do_emit;
        o_res.color   = e_color;
        o_res.idx     = e_idx;
        o_res.use_pal = i_cfg.use_palette;
        o_res.column  = r_column;
        o_res.row     = dest[11:0];
        o_res.repeats = finished ? 7'd0 : e_rep[6:0];
        o_res.last    = finished;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_ptr    <= '0;
            r_pal_phase  <= '0;
            r_map_held   <= '0;
            r_pix_phase  <= '0;
            r_held       <= '0;
            r_last_color <= '0;
            r_last_index <= '0;
            r_run_count  <= '0;
            r_run_rep    <= 1'b0;
            r_rep_ready  <= 1'b0;
            r_column     <= '0;
            r_true_row   <= '0;
            r_base_row   <= '0;
            r_rows_done  <= '0;
        end else begin
            r_pal_ptr    <= n_pal_ptr;
            r_pal_phase  <= n_pal_phase;
            r_map_held   <= n_map_held;
            r_pix_phase  <= n_pix_phase;
            r_held       <= n_held;
            r_last_color <= n_last_color;
            r_last_index <= n_last_index;
            r_run_count  <= n_run_count;
            r_run_rep    <= n_run_rep;
            r_rep_ready  <= n_rep_ready;
            r_column     <= n_column;
            r_true_row   <= n_true_row;
            r_base_row   <= n_base_row;
            r_rows_done  <= n_rows_done;
        end
    end

    a_pal_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pal_ptr <= PW'(tpsd_pkg::MAP_ENTRIES))
        else $error("palette pointer ran past the store");

    a_rep_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rep_ready |-> (r_run_count != 8'd0))
        else $error("repeat pending with an empty run");

    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_count <= 8'd128)
        else $error("run count above packet maximum");

endmodule

### design/targa_pixel_stream_decoder.sv
// ----------------------------------------------------------------------------
// Targa pixel stream decoder
// Decodes colormap and body bytes of a Targa image into placed RGBA pixels.
// ----------------------------------------------------------------------------
// Usage:
// Each input request carries a kind in s_axis_tuser (start image, colormap
// byte, body byte, pull one repeated pixel) and a file byte in s_axis_tdata.
// Colormap bytes fill the palette from entry 0; body bytes are assembled into
// pixels, raw or in run-length packets. A replicated run gives its first
// pixel on the byte that completes it and each further pixel on a pull.
// Each output request is one pixel with its color, column, destination row
// and pending repeat count; tlast marks the last pixel of the image and
// tuser flags a palette index beyond the store.
// One request is accepted every cycle while the decode stage is free. A pixel
// is registered first in the decode stage and then in the output register,
// together with the palette read, whose port is registered. Requests that
// cause no pixel pass without output.
// When the receiver stalls, the output register and the decode stage hold
// and the input keeps flowing until both are full.
// Reset clears all control state and loads the default registers; the
// palette contents stay undefined until written. The user must write registers
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module targa_pixel_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte [7:0]
    input  logic [1:0]  s_axis_tuser,   // kind [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // red [7:0], green [15:8], blue [23:16], alpha [31:24], column [43:32],
    // dest_row [55:44], repeats_left [62:56], zero [63]
    output logic [63:0] m_axis_tdata,
    output logic        m_axis_tlast,
    output logic        m_axis_tuser,   // index_error [0]
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);

    tpsd_pkg::t_cfg     r_cfg;
    tpsd_pkg::t_pal_wr  pal_wr;
    tpsd_pkg::t_result  res;
    tpsd_pkg::t_result  r_s1;
    tpsd_pkg::t_result  r_out;
    logic               res_valid;
    logic               r_s1_valid;
    logic               r_out_valid;
    logic [31:0]        r_pal_q;
    logic [31:0]        r_pal_mem [tpsd_pkg::MAP_ENTRIES];
    logic               accept;
    logic               out_ready;
    logic               s1_free;
    logic               s1_move;
    logic               idx_err;
    logic [31:0]        color;

    assign out_ready     = !r_out_valid || m_axis_tready;
    assign s1_move       = r_s1_valid && out_ready;
    assign s1_free       = !r_s1_valid || out_ready;
    assign s_axis_tready = s1_free;
    assign accept        = s_axis_tvalid && s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_format    <= tpsd_pkg::FMT_24;
            r_cfg.map_format      <= tpsd_pkg::FMT_24;
            r_cfg.use_palette     <= 1'b0;
            r_cfg.rle_enable      <= 1'b0;
            r_cfg.image_width     <= tpsd_pkg::DIM_W'(1);
            r_cfg.image_height    <= tpsd_pkg::DIM_W'(1);
            r_cfg.top_origin      <= 1'b0;
            r_cfg.interleave_mode <= 2'd0;
        end else if (i_cfg_we) begin
            case (tpsd_pkg::t_reg_index'(i_cfg_index))
                tpsd_pkg::REG_PIXEL_FORMAT: r_cfg.pixel_format    <= i_cfg_data[2:0];
                tpsd_pkg::REG_MAP_FORMAT:   r_cfg.map_format      <= i_cfg_data[2:0];
                tpsd_pkg::REG_USE_PALETTE:  r_cfg.use_palette     <= i_cfg_data[0];
                tpsd_pkg::REG_RLE_ENABLE:   r_cfg.rle_enable      <= i_cfg_data[0];
                tpsd_pkg::REG_IMAGE_WIDTH:  r_cfg.image_width     <= i_cfg_data;
                tpsd_pkg::REG_IMAGE_HEIGHT: r_cfg.image_height    <= i_cfg_data;
                tpsd_pkg::REG_TOP_ORIGIN:   r_cfg.top_origin      <= i_cfg_data[0];
                tpsd_pkg::REG_INTERLEAVE:   r_cfg.interleave_mode <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    tpsd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (accept),
        .i_kind      (tpsd_pkg::t_kind'(s_axis_tuser)),
        .i_byte      (s_axis_tdata),
        .i_cfg       (r_cfg),
        .o_pal_wr    (pal_wr),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= accept && res_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= res;
        end
        if (s1_move) begin
            r_out <= r_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pal_wr.en) begin
            r_pal_mem[pal_wr.addr] <= pal_wr.data;
        end
        if (s1_move) begin
            r_pal_q <= r_pal_mem[r_s1.idx[tpsd_pkg::MAP_AW-1:0]];
        end
    end

    assign idx_err = r_out.use_pal && (r_out.idx >= 16'(tpsd_pkg::MAP_ENTRIES));
    assign color   = !r_out.use_pal ? r_out.color : (idx_err ? 32'd0 : r_pal_q);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.repeats, r_out.row, r_out.column,
                            color[7:0], color[15:8], color[23:16], color[31:24]};
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tuser  = idx_err;

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_axis_tready)
        else $error("input stalled with an empty output register");

    a_last_no_repeats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last) |-> (r_out.repeats == 7'd0))
        else $error("final pixel reports pending repeats");

    a_err_zero_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && idx_err) |-> (m_axis_tdata[31:0] == 32'd0))
        else $error("out-of-store index with nonzero color");

endmodule
